@@ design/stsp_pkg.sv @@
package stsp_pkg;

	// Width of the internal character counter; chars_consumed is clamped to 16 bits.
	localparam int COUNT_BITS = 16;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_FIRST,
		PH_ZERO,
		PH_ZX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	localparam logic [5:0] BASE_AUTO = 6'd0;
	localparam logic [5:0] BASE_MIN  = 6'd2;
	localparam logic [5:0] BASE_OCT  = 6'd8;
	localparam logic [5:0] BASE_DEC  = 6'd10;
	localparam logic [5:0] BASE_HEX  = 6'd16;
	localparam logic [5:0] BASE_MAX  = 6'd36;
	localparam logic [5:0] NO_DIGIT  = 6'd36;

	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] chars_consumed;
		logic        converted;
		logic        overflowed;
	} result_t;

	typedef struct packed {
		logic [63:0] acc;
		logic [5:0]  base;
		logic [5:0]  digit;
		logic        neg;
	} mac_req_t;

	typedef struct packed {
		logic [63:0] acc;
		logic        ovf;
	} mac_rsp_t;

	// Value of a character as a digit in bases up to 36, or NO_DIGIT.
	function automatic logic [5:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = {2'b00, NO_DIGIT};
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = c - CH_ZERO;
			end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
				d = c - CH_UP_A + 8'd10;
			end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
				d = c - CH_LO_A + 8'd10;
			end
			return d[5:0];
		end
	endfunction

	// Space, tab, line feed, vertical tab, form feed and carriage return.
	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic count_t count_inc(input count_t c);
		return (c == '1) ? c : count_t'(c + count_t'(1));
	endfunction

	function automatic logic [15:0] count_clamp(input count_t c);
		logic [32:0] w;
		begin
			w = 33'(c);
			return (w > 33'h0_0000_FFFF) ? 16'hFFFF : w[15:0];
		end
	endfunction

endpackage

@@ design/string_to_signed_integer_parser.sv @@
// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+---------------------------------------------
// s_        | in  | s_tvalid/s_tready  | s_tdata[7:0] char_code
// m_        | out | m_tvalid/m_tready  | m_tdata value, chars_consumed; m_tuser flags
// cfg_      | in  | cfg_we             | cfg_wdata[5:0] number_base
//
// One character is taken per cycle while no held result stalls the parse step.
// An item waits in the input register, and its result, if it makes one, is written
// into the output register as the item advances. The two registers enclose a single
// parse step: one 64x6 multiply-add and one limit compare. Reset clears the parse
// state and the base register to auto-detect. A held result stalls the parse step;
// one more item can still be taken into the input register while a result waits.
module string_to_signed_integer_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [63:0] value, [79:64] chars_consumed
	output logic [1:0]  m_tuser,   // [0] converted, [1] overflowed
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata  // [5:0] number_base
);
	import stsp_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       advance;
	logic       emit;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;
	logic [5:0] base_q;

	// The number base is held here and sampled by the parser at the first character
	// after any whitespace and sign.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_AUTO;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// The input register moves on whenever the output register is free or is being
	// emptied in the same cycle, so a full stream runs at one item per cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	stsp_parse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.char_code   (char_s1),
		.number_base (base_q),
		.emit        (emit),
		.res         (res)
	);

	// Results are produced only by the character that ends a conversion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.chars_consumed, out_q.value};
	assign m_tuser  = {out_q.overflowed, out_q.converted};

endmodule

@@ design/stsp_digit_mac.sv @@
module stsp_digit_mac (
	input  stsp_pkg::mac_req_t req,
	output stsp_pkg::mac_rsp_t rsp
);
	import stsp_pkg::*;

	logic [69:0] prod;
	logic [70:0] sum;
	logic [70:0] top;

	// The wide sum is compared against the signed limit, which is the same test as
	// comparing the accumulator with limit/base and the digit with limit%base.
	always_comb begin
		prod    = 70'(req.acc) * 70'(req.base);
		sum     = 71'(prod) + 71'(req.digit);
		top     = req.neg ? 71'(S64_MIN) : 71'(S64_MAX);
		rsp.acc = sum[63:0];
		rsp.ovf = (sum > top);
	end

endmodule

@@ design/stsp_parse_core.sv @@
module stsp_parse_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_code,
	input  logic [5:0]        number_base,
	output logic              emit,
	output stsp_pkg::result_t res
);
	import stsp_pkg::*;

	phase_t      phase_q, phase_d;
	logic        neg_q, neg_d;
	logic [5:0]  base_q, base_d;
	logic [63:0] acc_q, acc_d;
	logic        seen_q, seen_d;
	logic        ovf_q, ovf_d;
	count_t      cnt_q, cnt_d;

	logic [5:0]  dig;
	logic        space;
	logic        fc_zero;
	logic [5:0]  fc_base;
	logic        fc_ok;
	logic [5:0]  dig_base;
	logic        digit_ok;
	count_t      cnt_inc1;
	count_t      cnt_inc2;
	mac_req_t    mac_req;
	mac_rsp_t    mac_rsp;

	stsp_digit_mac u_mac (
		.req (mac_req),
		.rsp (mac_rsp)
	);

	always_comb begin
		dig      = digit_of(char_code);
		space    = is_space(char_code);
		fc_zero  = ((number_base == BASE_AUTO) || (number_base == BASE_HEX)) &&
		           (char_code == CH_ZERO);
		fc_base  = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
		fc_ok    = (fc_base >= BASE_MIN) && (fc_base <= BASE_MAX);
		cnt_inc1 = count_inc(cnt_q);
		cnt_inc2 = count_inc(cnt_inc1);

		case (phase_q)
			PH_SPACE, PH_FIRST: dig_base = fc_base;
			PH_ZX:              dig_base = BASE_HEX;
			default:            dig_base = base_q;
		endcase
		digit_ok = (dig_base >= BASE_MIN) && (dig < dig_base);

		mac_req.acc   = acc_q;
		mac_req.base  = dig_base;
		mac_req.digit = dig;
		mac_req.neg   = neg_q;
	end

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		base_d  = base_q;
		acc_d   = acc_q;
		seen_d  = seen_q;
		ovf_d   = ovf_q;
		cnt_d   = cnt_q;
		emit    = 1'b0;

		case (phase_q)
			PH_SPACE, PH_FIRST: begin
				if ((phase_q == PH_SPACE) && space) begin
					cnt_d = cnt_inc1;
				end else if ((phase_q == PH_SPACE) &&
				             ((char_code == CH_MINUS) || (char_code == CH_PLUS))) begin
					neg_d   = (char_code == CH_MINUS);
					cnt_d   = cnt_inc1;
					phase_d = PH_FIRST;
				end else if (fc_zero) begin
					acc_d   = '0;
					seen_d  = 1'b1;
					cnt_d   = cnt_inc1;
					base_d  = (number_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
					phase_d = PH_ZERO;
				end else if (!fc_ok || !digit_ok) begin
					emit = 1'b1;
				end else begin
					base_d  = fc_base;
					acc_d   = (ovf_q || mac_rsp.ovf) ? acc_q : mac_rsp.acc;
					ovf_d   = ovf_q || mac_rsp.ovf;
					seen_d  = 1'b1;
					cnt_d   = cnt_inc1;
					phase_d = PH_DIGITS;
				end
			end
			PH_ZERO, PH_DIGITS, PH_ZX: begin
				if ((phase_q == PH_ZERO) &&
				    ((char_code == CH_LO_X) || (char_code == CH_UP_X))) begin
					phase_d = PH_ZX;
				end else if (!digit_ok) begin
					emit = 1'b1;
				end else begin
					// After a hex prefix both the x and the digit are counted.
					base_d  = dig_base;
					acc_d   = (ovf_q || mac_rsp.ovf) ? acc_q : mac_rsp.acc;
					ovf_d   = ovf_q || mac_rsp.ovf;
					seen_d  = 1'b1;
					cnt_d   = (phase_q == PH_ZX) ? cnt_inc2 : cnt_inc1;
					phase_d = PH_DIGITS;
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase

		// A terminating zero byte starts the next string at once; any other
		// character that ends the number leaves the string to be skipped.
		if (emit || (phase_q != PH_SPACE && phase_q != PH_FIRST && phase_q != PH_ZERO &&
		             phase_q != PH_ZX && phase_q != PH_DIGITS)) begin
			if (char_code == CH_NUL) begin
				phase_d = PH_SPACE;
				neg_d   = 1'b0;
				base_d  = '0;
				acc_d   = '0;
				seen_d  = 1'b0;
				ovf_d   = 1'b0;
				cnt_d   = '0;
			end else begin
				phase_d = PH_DONE;
			end
		end
	end

	always_comb begin
		res.value          = '0;
		res.chars_consumed = '0;
		if (seen_q) begin
			if (ovf_q) begin
				res.value = neg_q ? S64_MIN : S64_MAX;
			end else begin
				res.value = neg_q ? (64'd0 - acc_q) : acc_q;
			end
			res.chars_consumed = count_clamp(cnt_q);
		end
		res.converted  = seen_q;
		res.overflowed = seen_q && ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			base_q  <= '0;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			base_q  <= base_d;
			acc_q   <= acc_d;
			seen_q  <= seen_d;
			ovf_q   <= ovf_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

@@ design/stsp_checker.sv @@
module stsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A result that is not taken stays on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Without a conversion both the value and the count are zero.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata == 80'd0) && !m_tuser[1])
		else $error("non-zero result without a conversion");

	// A converted number has consumed at least its first digit.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[79:64] != 16'd0))
		else $error("conversion with zero characters consumed");

	// A clamped value is one of the two signed limits.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |->
		(m_tdata[63:0] == 64'h7FFF_FFFF_FFFF_FFFF) ||
		(m_tdata[63:0] == 64'h8000_0000_0000_0000))
		else $error("overflowed result is not a signed limit");

endmodule

bind string_to_signed_integer_parser stsp_checker u_stsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ tb/sv/tb_string_to_signed_integer_parser.sv @@
module tb_string_to_signed_integer_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import stsp_pkg::*;

	// The six characters that count as leading whitespace, space in the top byte.
	localparam logic [47:0] BLANKS = {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	localparam int DRAIN_LIMIT     = 5000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_CHARS     = 125;
	localparam int PRESSURE_PHASE  = 4;
	localparam int PRINT_LIMIT     = 50;

	localparam result_t NO_NUMBER = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;      // [7:0] char_code
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;           // [63:0] value, [79:64] chars_consumed
	logic [1:0]  m_tuser;           // [0] converted, [1] overflowed
	logic        cfg_we = 1'b0;
	logic [5:0]  cfg_wdata = '0;    // [5:0] number_base

	string_to_signed_integer_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Shadow of the parser: the base register and the state of the string in progress.
	logic [5:0]  number_base_reg;
	phase_t      str_phase;
	logic        str_neg;
	logic [5:0]  str_base;
	logic [63:0] str_acc;
	logic        str_has_digit;
	logic        str_clamped;
	count_t      str_chars;

	// Numbers the parser still owes us, oldest first.
	result_t     pending_numbers[$];

	// A directed string may carry a hand-written answer that replaces the prediction.
	bit          typed_pending = 1'b0;
	result_t     typed_number;

	int          mismatches = 0;

	// Pacing of both sides. The receiver reads its knobs only at clock edges, so they
	// are written with nonblocking assignments and every change is seen cleanly.
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          hold_off_req = 0;

	typedef struct {
		logic [5:0] base;
		string      text;
		bit         term;
		bit         typed;
		result_t    want;
	} text_row_t;

	text_row_t   script[$];

	function automatic void add_row(input logic [5:0] base, input string text, input bit term,
		input bit typed, input result_t want);
		text_row_t row;
		row.base = base;
		row.text = text;
		row.term = term;
		row.typed = typed;
		row.want = want;
		script.push_back(row);
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		for (int k = 0; k < 6; k++) begin
			if (BLANKS[8*k +: 8] == c) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Digit value in bases up to 36; 36 means the character is no digit at all.
	function automatic int unsigned char_digit(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			return 32'(c - CH_ZERO);
		end
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			return 32'(c - CH_UP_A) + 10;
		end
		if (c >= CH_LO_A && c <= CH_LO_Z) begin
			return 32'(c - CH_LO_A) + 10;
		end
		return 36;
	endfunction

	function automatic void clear_str();
		str_phase = PH_SPACE;
		str_neg = 1'b0;
		str_base = '0;
		str_acc = '0;
		str_has_digit = 1'b0;
		str_clamped = 1'b0;
		str_chars = '0;
	endfunction

	// The character counter sticks at its top value rather than wrapping.
	function automatic void bump_count();
		if (str_chars != '1) begin
			str_chars = str_chars + 1'b1;
		end
	endfunction

	// Closes the conversion. A zero byte also ends the string, so the next character
	// starts afresh; any other character leaves us skipping up to the zero byte.
	function automatic result_t finish_number(input logic [7:0] c);
		result_t     r;
		logic [32:0] wide;
		r = NO_NUMBER;
		wide = 33'(str_chars);
		if (str_has_digit) begin
			if (str_clamped) begin
				r.value = str_neg ? S64_MIN : S64_MAX;
			end else begin
				r.value = str_neg ? -str_acc : str_acc;
			end
			r.chars_consumed = (wide > 33'h0FFFF) ? 16'hFFFF : wide[15:0];
			r.converted = 1'b1;
			r.overflowed = str_clamped;
		end
		if (c == CH_NUL) begin
			clear_str();
		end else begin
			str_phase = PH_DONE;
		end
		return r;
	endfunction

	// Multiply-add with saturation: the magnitude may reach 2^63 only for a negative
	// number. Once clamped, later digits are still counted but leave the value alone.
	function automatic void take_digit(input int unsigned d);
		logic [63:0] top;
		logic [63:0] cut;
		logic [63:0] lim;
		top = str_neg ? S64_MIN : S64_MAX;
		cut = top / 64'(str_base);
		lim = top % 64'(str_base);
		if (str_clamped || str_acc > cut || (str_acc == cut && 64'(d) > lim)) begin
			str_clamped = 1'b1;
		end else begin
			str_acc = str_acc * 64'(str_base) + 64'(d);
		end
		str_has_digit = 1'b1;
		bump_count();
	endfunction

	function automatic bit digit_or_end(input logic [7:0] c, output result_t r);
		int unsigned d;
		d = char_digit(c);
		r = NO_NUMBER;
		if (str_base < BASE_MIN || d >= str_base) begin
			r = finish_number(c);
			return 1'b1;
		end
		take_digit(d);
		str_phase = PH_DIGITS;
		return 1'b0;
	endfunction

	// The shadow parser looks at the base register only here, at the first character past the
	// whitespace and sign. A leading zero in auto or hex mode may open a 0x prefix.
	function automatic bit first_digit(input logic [7:0] c, output result_t r);
		logic [5:0] b;
		b = number_base_reg;
		r = NO_NUMBER;
		if ((b == BASE_AUTO || b == BASE_HEX) && c == CH_ZERO) begin
			str_acc = '0;
			str_has_digit = 1'b1;
			bump_count();
			str_base = (b == BASE_AUTO) ? BASE_OCT : BASE_HEX;
			str_phase = PH_ZERO;
			return 1'b0;
		end
		if (b == BASE_AUTO) begin
			b = BASE_DEC;
		end
		if (b < BASE_MIN || b > BASE_MAX) begin
			r = finish_number(c);
			return 1'b1;
		end
		str_base = b;
		return digit_or_end(c, r);
	endfunction

	// One character into the shadow parser; returns 1 when it ends a conversion, with or without a number.
	function automatic bit parse_char(input logic [7:0] c, output result_t r);
		r = NO_NUMBER;
		case (str_phase)
			PH_SPACE: begin
				if (is_blank(c)) begin
					bump_count();
					return 1'b0;
				end
				if (c == CH_MINUS || c == CH_PLUS) begin
					str_neg = (c == CH_MINUS);
					bump_count();
					str_phase = PH_FIRST;
					return 1'b0;
				end
				return first_digit(c, r);
			end
			PH_FIRST: begin
				return first_digit(c, r);
			end
			PH_ZERO: begin
				// The x is not counted yet: only a hex digit after it makes the prefix real.
				if (c == CH_LO_X || c == CH_UP_X) begin
					str_phase = PH_ZX;
					return 1'b0;
				end
				return digit_or_end(c, r);
			end
			PH_ZX: begin
				if (char_digit(c) < 16) begin
					str_base = BASE_HEX;
					bump_count();
					take_digit(char_digit(c));
					str_phase = PH_DIGITS;
					return 1'b0;
				end
				r = finish_number(c);
				return 1'b1;
			end
			PH_DIGITS: begin
				return digit_or_end(c, r);
			end
			default: begin
				if (c == CH_NUL) begin
					clear_str();
				end
				return 1'b0;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < PRINT_LIMIT) begin
			$display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	// Offers one character, with a random gap first when the sender is meant to idle.
	// The valid line is only ever assigned once per clock edge.
	task automatic send_char(input logic [7:0] c);
		result_t r;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		if (parse_char(c, r)) begin
			pending_numbers.push_back(typed_pending ? typed_number : r);
			typed_pending = 1'b0;
		end
	endtask

	task automatic send_text(input string text, input bit term);
		for (int i = 0; i < text.len(); i++) begin
			send_char(8'(text[i]));
		end
		if (term) begin
			send_char(CH_NUL);
		end
	endtask

	function automatic logic [7:0] digit_char(input int unsigned d);
		if (d < 10) begin
			return CH_ZERO + 8'(d);
		end
		return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'(d - 10);
	endfunction

	// Most strings are well formed (blanks, sign, optional prefix, digits of the
	// current base, sometimes trailing junk); the rest are arbitrary bytes.
	task automatic send_random_string(output int count);
		logic [7:0]  txt[$];
		int unsigned b;
		int unsigned len;
		int unsigned form;
		b = 32'(number_base_reg);
		if (b == BASE_AUTO || b < BASE_MIN || b > BASE_MAX) begin
			b = BASE_DEC;
		end
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(6)) begin
				txt.push_back(8'($urandom_range(1, 255)));
			end
		end else begin
			repeat ($urandom_range(2)) begin
				txt.push_back(BLANKS[8*$urandom_range(5) +: 8]);
			end
			case ($urandom_range(3))
				0: txt.push_back(CH_MINUS);
				1: txt.push_back(CH_PLUS);
				default: ;
			endcase
			// Long runs reach the saturation limits; binary needs far more digits.
			if ($urandom_range(3) == 0) begin
				len = (b < 8) ? $urandom_range(20, 70) : $urandom_range(15, 24);
			end else begin
				len = $urandom_range(1, 6);
			end
			form = $urandom_range(9);
			if (form < 2) begin
				txt.push_back(CH_ZERO);
				txt.push_back($urandom_range(1) ? CH_UP_X : CH_LO_X);
				// A prefix with nothing after it leaves only the zero as the number.
				if ($urandom_range(4) == 0) begin
					len = 0;
				end
				repeat (len) begin
					txt.push_back(digit_char($urandom_range(15)));
				end
			end else begin
				if (form == 2) begin
					txt.push_back(CH_ZERO);
				end
				repeat (len) begin
					txt.push_back(digit_char($urandom_range(b - 1)));
				end
			end
			if ($urandom_range(3) != 0) begin
				repeat ($urandom_range(1, 4)) begin
					txt.push_back(8'($urandom_range(1, 255)));
				end
			end
		end
		txt.push_back(CH_NUL);
		count = txt.size();
		foreach (txt[i]) begin
			send_char(txt[i]);
		end
	endtask

	// Lets the parser run dry: every owed number in, then a settling wait for the
	// characters still in flight that make no number of their own.
	task automatic settle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (pending_numbers.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [5:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		number_base_reg = v;
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stalls at the rate of the current phase, and on request one
	// long hold-off during which the sender keeps pushing until the parser backs up.
	initial begin : downstream_ready
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req != hold_seen) begin
				hold_seen = hold_off_req;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Every item taken from the output is matched against the oldest owed number.
	always @(posedge clk) begin : check_numbers
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[63:0], m_tdata[79:64], m_tuser[0], m_tuser[1]};
			if (pending_numbers.size() == 0) begin
				report_mismatch("result with nothing owed", got.value, '0);
			end else begin
				want = pending_numbers.pop_front();
				if (got.value !== want.value) begin
					report_mismatch("value", got.value, want.value);
				end
				if (got.chars_consumed !== want.chars_consumed) begin
					report_mismatch("chars_consumed", 64'(got.chars_consumed),
						64'(want.chars_consumed));
				end
				if (got.converted !== want.converted) begin
					report_mismatch("converted", 64'(got.converted), 64'(want.converted));
				end
				if (got.overflowed !== want.overflowed) begin
					report_mismatch("overflowed", 64'(got.overflowed), 64'(want.overflowed));
				end
			end
		end
	end

	initial begin : stimulus
		int sent;
		int count;
		clear_str();
		number_base_reg = BASE_AUTO;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings. Where the answer is obvious it is written out here; the
		// rest go through the shadow parser. A row without its zero byte leaves the
		// string open so that the next row's base is written in the middle of it.
		add_row(BASE_AUTO, "", 1, 1, NO_NUMBER);
		add_row(BASE_AUTO, "9223372036854775807", 1, 1,
			result_t'({S64_MAX, 16'd19, 1'b1, 1'b0}));
		add_row(BASE_AUTO, "-9223372036854775808", 1, 1,
			result_t'({S64_MIN, 16'd20, 1'b1, 1'b0}));
		add_row(BASE_AUTO, "9223372036854775808", 1, 1,
			result_t'({S64_MAX, 16'd19, 1'b1, 1'b1}));
		add_row(BASE_AUTO, "-99999999999999999999", 1, 1,
			result_t'({S64_MIN, 16'd21, 1'b1, 1'b1}));
		add_row(BASE_AUTO, " \t\n\013\014\r+42z7", 1, 0, NO_NUMBER);
		add_row(BASE_AUTO, "0x1F", 1, 0, NO_NUMBER);
		add_row(BASE_AUTO, "0Xg", 1, 1, result_t'({64'd0, 16'd1, 1'b1, 1'b0}));
		add_row(BASE_AUTO, "0755", 1, 0, NO_NUMBER);
		add_row(BASE_AUTO, "-08", 1, 0, NO_NUMBER);
		add_row(BASE_AUTO, "-", 1, 1, NO_NUMBER);
		add_row(BASE_HEX, "0X7fffffffffffffff", 1, 0, NO_NUMBER);
		add_row(BASE_HEX, "-0xFFFFFFFFFFFFFFFF1", 1, 0, NO_NUMBER);
		add_row(BASE_HEX, "0x", 1, 0, NO_NUMBER);
		add_row(BASE_MIN, "-101012", 1, 0, NO_NUMBER);
		add_row(BASE_MAX, "+zZ09", 1, 0, NO_NUMBER);
		add_row(6'd1, "  -5", 1, 1, NO_NUMBER);
		add_row(6'd37, "5", 1, 1, NO_NUMBER);
		add_row(6'd63, "\377", 1, 1, NO_NUMBER);
		add_row(BASE_DEC, "12abc\001\377", 1, 0, NO_NUMBER);
		add_row(BASE_DEC, " +", 0, 0, NO_NUMBER);
		add_row(BASE_HEX, "ff", 1, 0, NO_NUMBER);
		add_row(BASE_OCT, "777", 1, 0, NO_NUMBER);

		foreach (script[i]) begin
			if (script[i].base != number_base_reg) begin
				settle();
				write_base(script[i].base);
			end
			typed_pending = script[i].typed;
			typed_number = script[i].want;
			send_text(script[i].text, script[i].term);
		end

		// Random strings in phases, each of which sets a base and a pacing of both sides.
		for (int p = 0; p < 8; p++) begin
			settle();
			case (p)
				0, 3: write_base(BASE_AUTO);
				1: write_base(BASE_DEC);
				2: write_base(BASE_HEX);
				4: write_base(BASE_MIN);
				5: write_base(BASE_MAX);
				6: write_base(BASE_OCT);
				default: write_base(6'($urandom_range(36)));
			endcase
			case (p % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
				end
				1: begin
					tx_idle_pct = 72;
					rx_stall_pct <= 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 72;
				end
				default: begin
					tx_idle_pct = 26;
					rx_stall_pct <= 26;
				end
			endcase
			sent = 0;
			while (sent < PHASE_CHARS) begin
				send_random_string(count);
				if (p == PRESSURE_PHASE && sent == 0) begin
					hold_off_req <= hold_off_req + 1;
				end
				sent += count;
			end
		end

		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		settle();
		if (pending_numbers.size() != 0) begin
			report_mismatch("results never delivered", '0, 64'(pending_numbers.size()));
		end
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Far beyond the slowest correct run, even with every phase at its worst pacing.
	initial begin : watchdog
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/stsp_pkg.sv
design/stsp_digit_mac.sv
design/stsp_parse_core.sv
design/string_to_signed_integer_parser.sv
design/stsp_checker.sv
tb/sv/tb_string_to_signed_integer_parser.sv
